[design/wmlc_pkg.sv]
// Shared types and constants for the windowed min-max linear classifier.
`default_nettype none

package wmlc_pkg;

    localparam int NUM_FEATURES = 5;
    localparam int FEAT_W       = 32;
    localparam int ROW_W        = NUM_FEATURES * FEAT_W;
    localparam int FEAT_IDX_W   = 3;

    localparam int NUM_REGS     = 6;
    localparam int REG_IDX_W    = 3;
    localparam int REG_W        = 32;

    // Configuration register indexes (weights 0..4 follow feature order)
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT_BAND = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BIAS        = 3'd5;

    localparam int Q_FRAC       = 16;
    localparam int DEC_W        = 48;
    localparam int TOTAL_W      = 51;
    localparam int AVG_W        = 33;
    localparam int PROD_W       = AVG_W + REG_W;

    // Shared divider: 48-bit numerator, 32-bit divisor, one quotient bit a cycle
    localparam int DIV_NUM_W    = 48;
    localparam int DIV_DEN_W    = 32;
    localparam int DIV_CNT_W    = 6;

    localparam logic [FEAT_W-1:0] SCALE_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [FEAT_W-1:0] SCALE_NEG_MAX = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MM_RD,
        ST_MM_USE,
        ST_FEAT,
        ST_SC_RD,
        ST_SC_LOAD,
        ST_SC_WAIT,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } seq_state_t;

endpackage

`default_nettype wire

[design/windowed_minmax_linear_classifier_unit.sv]
// Top level: window sequencer, min-max scaling and linear decision.
//
//  channel | ports                        | payload (low bit up)
//  --------+------------------------------+-----------------------------------------
//  input   | s_tvalid s_tready s_tdata    | band_power_sum, bin_power_a..d (5 x 32)
//  result  | m_tvalid m_tready m_tdata    | decision_value (48, signed Q32.16)
//          | m_tuser                      | detected, degenerate_range
//  config  | cfg_wr_en cfg_index cfg_wdata| weights 0..4, bias 5 (signed Q16.16)
//
// The first WINDOW_DEPTH items only fill the window and give no result. A later item
// runs the shared 48-step divider once per newer entry and non-flat feature, and once
// more per such feature to average the scaled values.
// Reset (aresetn low, synchronous) empties the window and clears the control and
// configuration registers.
// A result waiting on m_tready does not block the next item; only the final
// load of the next result waits for the output register to free up.
`default_nettype none

module windowed_minmax_linear_classifier_unit #(
    parameter int WINDOW_DEPTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // band_power_sum, bin_power_a, bin_power_b, bin_power_c, bin_power_d
    input  wire logic [wmlc_pkg::ROW_W-1:0]     s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // decision_value
    output logic [wmlc_pkg::DEC_W-1:0]          m_tdata,
    // detected, degenerate_range
    output logic [1:0]                          m_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_wr_en,
    input  wire logic [wmlc_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [wmlc_pkg::REG_W-1:0]     cfg_wdata
);
    import wmlc_pkg::*;

    localparam int AW        = $clog2(WINDOW_DEPTH);
    localparam int FW        = $clog2(WINDOW_DEPTH + 1);
    localparam int OLD_HALF  = WINDOW_DEPTH / 2;
    localparam int NEW_COUNT = WINDOW_DEPTH - OLD_HALF;
    localparam int SUM_W     = 33 + $clog2(NEW_COUNT + 1);

    // configuration
    logic signed [REG_W-1:0] weight_reg [NUM_FEATURES];
    logic signed [REG_W-1:0] bias_reg;

    // control
    seq_state_t           state_reg, state_next;
    logic [FW-1:0]        fill_reg;
    logic [AW-1:0]        head_reg;
    logic [AW-1:0]        rd_ptr_reg;
    logic [AW-1:0]        cnt_reg;
    logic [FEAT_IDX_W-1:0] feat_reg;
    logic                 out_valid_reg;

    // datapath
    logic [FEAT_W-1:0]          lo_reg [NUM_FEATURES];
    logic [FEAT_W-1:0]          hi_reg [NUM_FEATURES];
    logic                       neg_reg;
    logic                       deg_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [AVG_W-1:0]    avg_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [TOTAL_W-1:0]  total_reg;
    logic [DEC_W-1:0]           out_dec_reg;
    logic                       out_det_reg;
    logic                       out_deg_reg;

    // memory and divider hookup
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic                   mem_re;
    logic [ROW_W-1:0]       mem_rdata;
    logic                   div_start;
    logic [DIV_NUM_W-1:0]   div_num;
    logic [DIV_DEN_W-1:0]   div_den;
    logic                   div_busy;
    logic                   div_done;
    logic [DIV_NUM_W-1:0]   div_quot;

    logic                   in_accept;
    logic                   filling;
    logic                   out_free;
    logic                   out_load;
    logic [AW-1:0]          head_inc;
    logic [AW-1:0]          ptr_inc;
    logic [AW:0]            new_start_sum;
    logic [AW-1:0]          new_start;
    logic [FEAT_W-1:0]      cur_val;
    logic [FEAT_W-1:0]      cur_lo;
    logic [FEAT_W-1:0]      cur_hi;
    logic [FEAT_W-1:0]      cur_diff;
    logic [FEAT_W-1:0]      cur_range;
    logic                   cur_neg;
    logic [FEAT_W-1:0]      sc_mag;
    logic signed [SUM_W-1:0] sc_signed;
    logic [SUM_W-1:0]       sum_abs;
    logic signed [AVG_W-1:0] q_avg;
    logic signed [TOTAL_W-1:0] total_sat_lo;
    logic signed [TOTAL_W-1:0] dec_max;
    logic signed [TOTAL_W-1:0] dec_min;
    logic [DEC_W-1:0]       dec_val;

    wmlc_window_mem #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (s_tdata),
        .rd_en   (mem_re),
        .rd_addr (rd_ptr_reg),
        .rd_data (mem_rdata)
    );

    wmlc_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_num),
        .denom   (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ---- configuration writes ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_FEATURES; j++) begin
                weight_reg[j] <= '0;
            end
            bias_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_BIAS) begin
                bias_reg <= cfg_wdata;
            end else if (cfg_index < REG_BIAS) begin
                weight_reg[cfg_index - REG_WEIGHT_BAND] <= cfg_wdata;
            end
        end
    end

    // ---- shared combinational helpers ----
    always_comb begin
        in_accept     = s_tvalid && s_tready;
        filling       = (fill_reg < FW'(WINDOW_DEPTH));
        out_free      = !out_valid_reg || m_tready;
        head_inc      = (head_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        ptr_inc       = (rd_ptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        new_start_sum = {1'b0, head_reg} + (AW + 1)'(OLD_HALF);
        new_start     = (new_start_sum >= (AW + 1)'(WINDOW_DEPTH))
                      ? AW'(new_start_sum - (AW + 1)'(WINDOW_DEPTH))
                      : new_start_sum[AW-1:0];
        mem_waddr     = filling ? fill_reg[AW-1:0] : head_reg;

        // scaling of the current newer entry
        cur_val   = mem_rdata[feat_reg * FEAT_W +: FEAT_W];
        cur_lo    = lo_reg[feat_reg];
        cur_hi    = hi_reg[feat_reg];
        cur_neg   = (cur_val < cur_lo);
        cur_diff  = cur_neg ? (cur_lo - cur_val) : (cur_val - cur_lo);
        cur_range = cur_hi - cur_lo;

        // saturate the divider quotient to the Q16.16 range
        if (neg_reg) begin
            sc_mag    = (div_quot > DIV_NUM_W'(SCALE_NEG_MAX)) ? SCALE_NEG_MAX
                                                               : div_quot[FEAT_W-1:0];
            sc_signed = -$signed({{(SUM_W - FEAT_W){1'b0}}, sc_mag});
        end else begin
            sc_mag    = (div_quot > DIV_NUM_W'(SCALE_POS_MAX)) ? SCALE_POS_MAX
                                                               : div_quot[FEAT_W-1:0];
            sc_signed = $signed({{(SUM_W - FEAT_W){1'b0}}, sc_mag});
        end

        sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        q_avg   = neg_reg ? -$signed({1'b0, div_quot[AVG_W-2:0]})
                          : $signed({1'b0, div_quot[AVG_W-2:0]});

        // saturate the decision value to 48 bits
        dec_max      = TOTAL_W'({1'b0, {(DEC_W - 1){1'b1}}});
        dec_min      = ~dec_max;
        total_sat_lo = (total_reg < dec_min) ? dec_min : total_reg;
        dec_val      = (total_reg > dec_max) ? DEC_W'(dec_max) : DEC_W'(total_sat_lo);
    end

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && !filling) begin
                    state_next = ST_MM_RD;
                end
            end
            ST_MM_RD:  state_next = ST_MM_USE;
            ST_MM_USE: begin
                if (cnt_reg == AW'(OLD_HALF - 1)) begin
                    state_next = ST_FEAT;
                end else begin
                    state_next = ST_MM_RD;
                end
            end
            ST_FEAT: begin
                if (feat_reg == FEAT_IDX_W'(NUM_FEATURES)) begin
                    state_next = ST_OUT;
                end else if (cur_lo != cur_hi) begin
                    state_next = ST_SC_RD;
                end
            end
            ST_SC_RD:   state_next = ST_SC_LOAD;
            ST_SC_LOAD: state_next = ST_SC_WAIT;
            ST_SC_WAIT: begin
                if (div_done) begin
                    if (cnt_reg == AW'(NEW_COUNT - 1)) begin
                        state_next = ST_AVG_START;
                    end else begin
                        state_next = ST_SC_RD;
                    end
                end
            end
            ST_AVG_START: state_next = ST_AVG_WAIT;
            ST_AVG_WAIT: begin
                if (div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_ACC;
            ST_ACC: state_next = ST_FEAT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---- sequencer outputs ----
    always_comb begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        div_start = 1'b0;
        div_num   = {cur_diff, {Q_FRAC{1'b0}}};
        div_den   = cur_range;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                mem_we   = s_tvalid;
            end
            ST_MM_RD, ST_SC_RD: mem_re = 1'b1;
            ST_SC_LOAD: div_start = 1'b1;
            ST_AVG_START: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(sum_abs);
                div_den   = DIV_DEN_W'(NEW_COUNT);
            end
            ST_OUT: out_load = out_free;
            ST_MM_USE, ST_FEAT, ST_SC_WAIT, ST_AVG_WAIT, ST_MUL, ST_ACC: begin
            end
            default: begin
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_accept) begin
                if (filling) begin
                    fill_reg <= fill_reg + 1'b1;
                end else begin
                    head_reg <= head_inc;
                end
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                // start the scan at the new oldest entry
                rd_ptr_reg <= head_inc;
                cnt_reg    <= '0;
                feat_reg   <= '0;
                deg_reg    <= 1'b0;
                total_reg  <= TOTAL_W'(bias_reg);
                for (int j = 0; j < NUM_FEATURES; j++) begin
                    lo_reg[j] <= '1;
                    hi_reg[j] <= '0;
                end
            end
            ST_MM_USE: begin
                for (int j = 0; j < NUM_FEATURES; j++) begin
                    if (mem_rdata[j * FEAT_W +: FEAT_W] < lo_reg[j]) begin
                        lo_reg[j] <= mem_rdata[j * FEAT_W +: FEAT_W];
                    end
                    if (mem_rdata[j * FEAT_W +: FEAT_W] > hi_reg[j]) begin
                        hi_reg[j] <= mem_rdata[j * FEAT_W +: FEAT_W];
                    end
                end
                rd_ptr_reg <= ptr_inc;
                cnt_reg    <= cnt_reg + 1'b1;
            end
            ST_FEAT: begin
                if (feat_reg != FEAT_IDX_W'(NUM_FEATURES)) begin
                    if (cur_lo == cur_hi) begin
                        // flat range: drop this feature
                        deg_reg  <= 1'b1;
                        feat_reg <= feat_reg + 1'b1;
                    end else begin
                        rd_ptr_reg <= new_start;
                        cnt_reg    <= '0;
                        sum_reg    <= '0;
                    end
                end
            end
            ST_SC_LOAD: neg_reg <= cur_neg;
            ST_SC_WAIT: begin
                if (div_done) begin
                    sum_reg    <= sum_reg + sc_signed;
                    rd_ptr_reg <= ptr_inc;
                    cnt_reg    <= cnt_reg + 1'b1;
                end
            end
            ST_AVG_START: neg_reg <= sum_reg[SUM_W-1];
            ST_AVG_WAIT: begin
                if (div_done) begin
                    avg_reg <= q_avg;
                end
            end
            ST_MUL: prod_reg <= avg_reg * $signed(weight_reg[feat_reg]);
            ST_ACC: begin
                // floor shift of the Q33.32 product back to Q33.16
                total_reg <= total_reg + TOTAL_W'($signed(prod_reg[PROD_W-1:Q_FRAC]));
                feat_reg  <= feat_reg + 1'b1;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_dec_reg <= dec_val;
                    out_det_reg <= (total_reg > 0);
                    out_deg_reg <= deg_reg;
                end
            end
            ST_MM_RD, ST_SC_RD: begin
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_dec_reg;
    assign m_tuser  = {out_deg_reg, out_det_reg};

    // ---- assertions ----
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(WINDOW_DEPTH))
        else $error("window fill count beyond depth");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a waiting result");

    a_head_still_while_filling: assert property (@(posedge aclk) disable iff (!aresetn)
        (filling && !$past(in_accept && !filling)) |-> head_reg == '0)
        else $error("window head moved before the window was full");

endmodule

`default_nettype wire

[design/wmlc_divider.sv]
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module wmlc_divider (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [wmlc_pkg::DIV_NUM_W-1:0] numer,
    input  wire logic [wmlc_pkg::DIV_DEN_W-1:0] denom,
    output logic                                busy,
    output logic                                done,
    output logic [wmlc_pkg::DIV_NUM_W-1:0]      quot
);
    import wmlc_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;

    always_comb begin
        rem_sh  = {rem_reg, q_reg[DIV_NUM_W-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg   <= numer;
            den_reg <= denom;
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            q_reg   <= {q_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

[design/wmlc_window_mem.sv]
// Window storage: one row of five features per entry, registered read.
`default_nettype none

module wmlc_window_mem #(
    parameter int DEPTH = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [wmlc_pkg::ROW_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [wmlc_pkg::ROW_W-1:0]      rd_data
);
    import wmlc_pkg::*;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[dv/windowed_minmax_linear_classifier_unit_tb.sv]
// Self-checking testbench for the windowed min-max linear classifier unit.
`default_nettype none

module windowed_minmax_linear_classifier_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wmlc_pkg::*;

    localparam int DEPTH      = 16;
    localparam int OLDER      = DEPTH / 2;
    localparam int NEWER      = DEPTH - OLDER;
    // Settle time covers the worst item, with margin for draining and config.
    localparam int SETTLE     = 3000;
    localparam longint LIMIT  = 40_000_000;
    localparam longint DEC_HI = 64'sd140737488355327;
    localparam longint DEC_LO = -64'sd140737488355328;

    typedef struct {
        logic [DEC_W-1:0] decision;
        logic             detected;
        logic             degenerate;
    } verdict_t;

    logic               aclk;
    logic               aresetn;
    logic [ROW_W-1:0]   s_tdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [DEC_W-1:0]   m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic               cfg_wr_en;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]   cfg_wdata;

    windowed_minmax_linear_classifier_unit #(.WINDOW_DEPTH(DEPTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Shadow of the block's state, used by the predictor.
    logic [FEAT_W-1:0] win_mem [DEPTH][NUM_FEATURES];
    int                win_head;
    int                win_fill;
    longint            coef [NUM_REGS];

    logic [ROW_W-1:0]  pending_items[$];
    verdict_t          expected_verdicts[$];
    int                mismatches;
    bit                quiet_sender;
    bit                quiet_receiver;
    int                send_gap;
    int                recv_gap;
    longint            cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Append one vector to the stimulus queue.
    function automatic void queue_item(logic [ROW_W-1:0] row);
        pending_items.insert(pending_items.size(), row);
    endfunction

    // Scale one newer value against the older-half range, saturated to Q16.16.
    function automatic longint scale_q16(logic [31:0] x, logic [31:0] lo, logic [31:0] hi);
        longint unsigned span;
        longint unsigned mag;
        span = 64'(hi - lo);
        if (x >= lo) begin
            mag = (64'(x - lo) << 16) / span;
            if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
            return longint'(mag);
        end
        mag = (64'(lo - x) << 16) / span;
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        return -longint'(mag);
    endfunction

    // Insert one vector; return 1 with a verdict once the window is full.
    function automatic bit classify(logic [ROW_W-1:0] row, output verdict_t v);
        int     slot;
        longint total;
        longint sum;
        longint avg;
        logic [31:0] lo, hi, x;
        bit     degen;
        degen = 0;
        if (win_fill < DEPTH) begin
            slot = (win_head + win_fill) % DEPTH;
            for (int j = 0; j < NUM_FEATURES; j++) win_mem[slot][j] = row[j*FEAT_W +: FEAT_W];
            win_fill++;
            return 0;
        end
        for (int j = 0; j < NUM_FEATURES; j++) win_mem[win_head][j] = row[j*FEAT_W +: FEAT_W];
        win_head = (win_head + 1) % DEPTH;
        total = coef[REG_BIAS];
        for (int j = 0; j < NUM_FEATURES; j++) begin
            lo = win_mem[win_head][j];
            hi = lo;
            for (int i = 0; i < OLDER; i++) begin
                x = win_mem[(win_head + i) % DEPTH][j];
                if (x < lo) lo = x;
                if (x > hi) hi = x;
            end
            if (hi == lo) begin
                degen = 1;
                continue;
            end
            sum = 0;
            for (int i = OLDER; i < DEPTH; i++)
                sum += scale_q16(win_mem[(win_head + i) % DEPTH][j], lo, hi);
            avg = sum / NEWER;
            // arithmetic shift of a signed product floors
            total += (avg * coef[REG_WEIGHT_BAND + j]) >>> Q_FRAC;
        end
        if (total > DEC_HI) total = DEC_HI;
        if (total < DEC_LO) total = DEC_LO;
        v.decision   = total[DEC_W-1:0];
        v.detected   = total > 0;
        v.degenerate = degen;
        return 1;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int draw_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(5, 60);
    endfunction

    // Driver: predict on each accepted item, then present the next one.
    always @(posedge aclk) begin
        verdict_t v;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (classify(s_tdata, v))
                    expected_verdicts.insert(expected_verdicts.size(), v);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_tdata  <= pending_items[0];
                    pending_items.delete(0);
                    s_tvalid <= 1'b1;
                    send_gap <= quiet_sender ? 0 : draw_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        verdict_t v;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: decision=%h flags=%b", m_tdata, m_tuser);
                end else begin
                    v = expected_verdicts[0];
                    expected_verdicts.delete(0);
                    if (m_tdata !== v.decision || m_tuser[0] !== v.detected ||
                        m_tuser[1] !== v.degenerate) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: decision exp %h got %h, detected exp %b got %b, degenerate exp %b got %b",
                                     v.decision, m_tdata, v.detected, m_tuser[0],
                                     v.degenerate, m_tuser[1]);
                    end
                end
            end
            // hold off the receiver for a while, or accept at once
            if (quiet_receiver) begin
                m_tready <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap <= draw_gap();
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx < NUM_REGS) coef[idx] = longint'($signed(val));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait for the block to drain, then let any in-flight item settle.
    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_weights(int mode);
        logic [REG_W-1:0] w;
        for (int r = 0; r < NUM_REGS; r++) begin
            case (mode)
                0: w = 32'h7FFF_FFFF;
                1: w = 32'h8000_0000;
                2: w = (r % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                3: w = 32'h0001_0000 * $urandom_range(0, 4) - 32'h0002_0000;
                default: w = $urandom();
            endcase
            write_reg(REG_IDX_W'(REG_WEIGHT_BAND + r), w);
        end
    endtask

    function automatic logic [ROW_W-1:0] row_of(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] c, logic [31:0] d,
                                               logic [31:0] e);
        return {e, d, c, b, a};
    endfunction

    // Per-feature value styles for random vectors, redrawn every 20 items.
    int          style [NUM_FEATURES];
    logic [31:0] anchor [NUM_FEATURES];

    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] row;
        logic [31:0]      x;
        for (int j = 0; j < NUM_FEATURES; j++) begin
            case (style[j])
                0: x = $urandom();
                1: x = anchor[j] + $urandom_range(0, 1000);
                2: x = anchor[j];
                default: x = anchor[j] ^ (32'h1 << $urandom_range(0, 31));
            endcase
            row[j*FEAT_W +: FEAT_W] = x;
        end
        return row;
    endfunction

    initial begin
        mismatches     = 0;
        cycles         = 0;
        win_head       = 0;
        win_fill       = 0;
        quiet_sender   = 0;
        quiet_receiver = 0;
        for (int r = 0; r < NUM_REGS; r++) coef[r] = 0;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset weights, all-zero window gives degenerate features.
        repeat (DEPTH + 1) queue_item('0);
        drain();

        // Extremes: narrow older range, far-off newer values to saturate.
        set_weights(0);
        write_reg(REG_IDX_W'(NUM_REGS), 32'hDEAD_BEEF);    // out of range, ignored
        write_reg(3'd7, 32'h1234_5678);
        for (int i = 0; i < 8; i++)
            queue_item(row_of(i % 2, 100 + i % 2, 32'hFFFF_FFFE + i % 2,
                              i % 2, 32'h8000_0000 + i % 2));
        queue_item(row_of('1, '1, 0, '1, 0));
        queue_item(row_of(0, '1, '1, '1, '1));
        drain();
        set_weights(1);
        queue_item(row_of('1, 0, '0, '1, 32'h5555_5555));
        queue_item(row_of(32'hAAAA_AAAA, 7, 9, 0, '1));
        drain();

        // Random phases cycle through weight settings and idling modes.
        for (int phase = 0; phase < 7; phase++) begin
            set_weights(phase < 2 ? phase + 2 : 4 + phase % 2);
            quiet_sender   = (phase == 3);
            quiet_receiver = (phase == 3 || phase == 5);
            for (int n = 0; n < 200; n++) begin
                if (n % 20 == 0) begin
                    for (int j = 0; j < NUM_FEATURES; j++) begin
                        style[j]  = $urandom_range(0, 9) < 4 ? 0 : $urandom_range(1, 3);
                        anchor[j] = $urandom();
                    end
                end
                queue_item(random_row());
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
design/wmlc_pkg.sv
design/wmlc_divider.sv
design/wmlc_window_mem.sv
design/windowed_minmax_linear_classifier_unit.sv
dv/windowed_minmax_linear_classifier_unit_tb.sv
